[rtl/ttc_pkg.sv]
package ttc_pkg;

   localparam int POS_W   = 32;
   localparam int UV_W    = 20;
   localparam int EDGE_W  = POS_W + 1;
   localparam int DUV_W   = UV_W + 1;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int DIV_W   = 2 * DUV_W + 1;
   localparam int TAN_W   = 58;
   localparam int MAG_W   = TAN_W - 1;
   localparam int NORM_W  = 31;
   localparam int SUM_W   = 64;
   localparam int LEN_W   = 32;
   localparam int FRAC_W  = 14;
   localparam int QUO_W   = FRAC_W + 1;
   localparam int REM_W   = NORM_W + FRAC_W + 2;
   localparam int OUT_W   = 16;
   localparam int SQRT_STEPS = SUM_W / 2;

   localparam logic [1:0] CORNER_0 = 2'd0;
   localparam logic [1:0] CORNER_1 = 2'd1;
   localparam logic [1:0] CORNER_2 = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SIGN,
      ST_SHIFT,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[rtl/triangle_tangent_calc_unit.sv]
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  corner, pos_x/y/z, tex_u/v
// rsp       out        rsp_valid/rsp_stall  tangent_x/y/z, handed_negative, degenerate
//
// corners 0 and 1 are stored in their accept cycle; corner 2 runs 8 multiply steps, 1 sign
// step, 1 check plus up to 22 shift steps, 3 square steps, 32 root steps, 3 x 16 divide
// steps (load plus 15 quotient bits) and a done state; the multiply and square steps share one
// 33x33 multiplier, no request is taken meanwhile, and a degenerate triangle skips to done
// reset (synchronous) clears the held corners, the sequencer and rsp_valid
// a result waits in the output register; corners 0 and 1 are taken meanwhile, and a
// finished corner 2 waits in its last state until the output register is free
module triangle_tangent_calc_unit
   import ttc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_corner,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic signed [UV_W-1:0]   req_tex_u,
   input  logic signed [UV_W-1:0]   req_tex_v,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_tangent_x,
   output logic signed [OUT_W-1:0]  rsp_tangent_y,
   output logic signed [OUT_W-1:0]  rsp_tangent_z,
   output logic                     rsp_handed_negative,
   output logic                     rsp_degenerate
);

   // held corners
   logic signed [POS_W-1:0]  pos0_ff [3];
   logic signed [POS_W-1:0]  pos1_ff [3];
   logic signed [UV_W-1:0]   uv0_ff [2];
   logic signed [UV_W-1:0]   uv1_ff [2];

   // working registers
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [DUV_W-1:0]  du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [DIV_W-1:0]  div_ff;
   logic signed [TAN_W-1:0]  t_ff [3];
   logic [MAG_W-1:0]         mag_ff [3];
   logic                     neg_ff [3];
   logic [SUM_W-1:0]         sum_ff;
   logic [SUM_W-1:0]         root_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic [QUO_W-1:0]         q_ff [3];
   logic [4:0]               cnt_ff;
   logic [1:0]               comp_ff;
   logic                     loaded_ff;
   state_type                state_ff, state_in;

   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  tan_out_ff [3];
   logic                     handed_ff, deg_ff;

   logic req_take;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   logic signed [POS_W-1:0] req_pos [3];
   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   assign prod = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQUARE) begin
         mul_a = $signed({2'b00, mag_ff[comp_ff][NORM_W-1:0]});
         mul_b = mul_a;
      end else begin
         unique case (cnt_ff[2:0])
            3'd0: begin mul_a = MUL_W'(du1_ff); mul_b = MUL_W'(dv2_ff); end
            3'd1: begin mul_a = MUL_W'(du2_ff); mul_b = MUL_W'(dv1_ff); end
            3'd2: begin mul_a = e1_ff[0]; mul_b = MUL_W'(dv2_ff); end
            3'd3: begin mul_a = e2_ff[0]; mul_b = MUL_W'(dv1_ff); end
            3'd4: begin mul_a = e1_ff[1]; mul_b = MUL_W'(dv2_ff); end
            3'd5: begin mul_a = e2_ff[1]; mul_b = MUL_W'(dv1_ff); end
            3'd6: begin mul_a = e1_ff[2]; mul_b = MUL_W'(dv2_ff); end
            3'd7: begin mul_a = e2_ff[2]; mul_b = MUL_W'(dv1_ff); end
            default: ;
         endcase
      end
   end

   // root step
   logic [SUM_W-1:0] sq_bit;
   logic [SUM_W:0]   sq_trial;
   logic             sq_fit;
   assign sq_bit   = SUM_W'(1) << (6'(SUM_W - 2) - {cnt_ff, 1'b0});
   assign sq_trial = {1'b0, root_ff} + {1'b0, sq_bit};
   assign sq_fit   = {1'b0, sum_ff} >= sq_trial;

   // divide step
   logic [REM_W-1:0] dv_shift;
   logic             dv_fit;
   assign dv_shift = REM_W'(root_ff[LEN_W-1:0]) << cnt_ff[3:0];
   assign dv_fit   = rem_ff >= dv_shift;

   logic any_big, all_zero;
   assign any_big  = (|mag_ff[0][MAG_W-1:NORM_W]) || (|mag_ff[1][MAG_W-1:NORM_W])
                  || (|mag_ff[2][MAG_W-1:NORM_W]);
   assign all_zero = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take && req_corner == CORNER_2) state_in = ST_MUL;
         ST_MUL:    if (cnt_ff[2:0] == 3'd7) state_in = ST_SIGN;
         ST_SIGN:   state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (div_ff == '0 || all_zero) state_in = ST_DONE;
            else if (!any_big) state_in = ST_SQUARE;
         end
         ST_SQUARE: if (comp_ff == 2'd2) state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == 5'(SQRT_STEPS - 1)) state_in = ST_DIV;
         ST_DIV:    if (loaded_ff && cnt_ff[3:0] == 4'd0 && comp_ff == 2'd2) state_in = ST_DONE;
         ST_DONE:   if (!(rsp_valid_ff && rsp_stall)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // held corners, reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            pos0_ff[k] <= '0;
            pos1_ff[k] <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            uv0_ff[k] <= '0;
            uv1_ff[k] <= '0;
         end
      end else if (req_take) begin
         if (req_corner == CORNER_0) begin
            for (int k = 0; k < 3; k++) pos0_ff[k] <= req_pos[k];
            uv0_ff[0] <= req_tex_u;
            uv0_ff[1] <= req_tex_v;
         end else if (req_corner == CORNER_1) begin
            for (int k = 0; k < 3; k++) pos1_ff[k] <= req_pos[k];
            uv1_ff[0] <= req_tex_u;
            uv1_ff[1] <= req_tex_v;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            cnt_ff  <= '0;
            comp_ff <= '0;
            if (req_take && req_corner == CORNER_2) begin
               for (int k = 0; k < 3; k++) begin
                  e1_ff[k] <= EDGE_W'(pos1_ff[k]) - EDGE_W'(pos0_ff[k]);
                  e2_ff[k] <= EDGE_W'(req_pos[k]) - EDGE_W'(pos0_ff[k]);
               end
               du1_ff <= DUV_W'(uv1_ff[0]) - DUV_W'(uv0_ff[0]);
               dv1_ff <= DUV_W'(uv1_ff[1]) - DUV_W'(uv0_ff[1]);
               du2_ff <= DUV_W'(req_tex_u) - DUV_W'(uv0_ff[0]);
               dv2_ff <= DUV_W'(req_tex_v) - DUV_W'(uv0_ff[1]);
            end
         end
         ST_MUL: begin
            // even step loads the first product, odd step subtracts the second
            if (!cnt_ff[0]) acc_ff <= prod;
            else if (cnt_ff[2:1] == 2'd0) div_ff <= DIV_W'(acc_ff - prod);
            else t_ff[cnt_ff[2:1] - 2'd1] <= TAN_W'(acc_ff - prod);
            cnt_ff <= (cnt_ff[2:0] == 3'd7) ? 5'd0 : cnt_ff + 5'd1;
         end
         ST_SIGN: begin
            for (int k = 0; k < 3; k++) begin
               logic signed [TAN_W-1:0] ts;
               ts = (div_ff < 0) ? -t_ff[k] : t_ff[k];
               neg_ff[k] <= ts < 0;
               mag_ff[k] <= (ts < 0) ? MAG_W'(-ts) : MAG_W'(ts);
            end
            sum_ff <= '0;
         end
         ST_SHIFT: begin
            if (any_big) for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
            root_ff <= '0;
         end
         ST_SQUARE: begin
            sum_ff  <= sum_ff + prod[SUM_W-1:0];
            comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
            cnt_ff  <= '0;
         end
         ST_SQRT: begin
            if (sq_fit) begin
               sum_ff  <= sum_ff - sq_trial[SUM_W-1:0];
               root_ff <= (root_ff >> 1) + sq_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
            cnt_ff    <= (cnt_ff == 5'(SQRT_STEPS - 1)) ? 5'd0 : cnt_ff + 5'd1;
            loaded_ff <= 1'b0;
         end
         ST_DIV: begin
            if (!loaded_ff) begin
               // numerator: magnitude in Q14 plus half the length
               rem_ff    <= (REM_W'(mag_ff[comp_ff][NORM_W-1:0]) << FRAC_W)
                          + REM_W'(root_ff[LEN_W-1:1]);
               quo_ff    <= '0;
               cnt_ff    <= 5'(QUO_W - 1);
               loaded_ff <= 1'b1;
            end else begin
               if (dv_fit) rem_ff <= rem_ff - dv_shift;
               if (cnt_ff[3:0] == 4'd0) begin
                  q_ff[comp_ff] <= {quo_ff[QUO_W-1:1], dv_fit};
                  comp_ff       <= comp_ff + 2'd1;
                  loaded_ff     <= 1'b0;
               end else begin
                  quo_ff <= quo_ff | (QUO_W'(dv_fit) << cnt_ff[3:0]);
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // output register
   logic result_deg;
   assign result_deg = (div_ff == '0) || all_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall)) begin
         for (int k = 0; k < 3; k++) begin
            if (result_deg) tan_out_ff[k] <= '0;
            else tan_out_ff[k] <= neg_ff[k] ? -OUT_W'(q_ff[k]) : OUT_W'(q_ff[k]);
         end
         handed_ff <= div_ff > 0;
         deg_ff    <= result_deg;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tangent_x       = tan_out_ff[0];
   assign rsp_tangent_y       = tan_out_ff[1];
   assign rsp_tangent_z       = tan_out_ff[2];
   assign rsp_handed_negative = handed_ff;
   assign rsp_degenerate      = deg_ff;

endmodule

[rtl/ttc_checker.sv]
module ttc_checker
   import ttc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [1:0]              req_corner,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [OUT_W-1:0] rsp_tangent_x,
   input logic signed [OUT_W-1:0] rsp_tangent_y,
   input logic signed [OUT_W-1:0] rsp_tangent_z,
   input logic                    rsp_degenerate
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tangent_x)
         && $stable(rsp_tangent_y) && $stable(rsp_tangent_z))
      else $error("stalled result changed");

   // a third corner keeps the unit busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_corner == CORNER_2 |=> req_stall)
      else $error("third corner did not start the sequencer");

   // degenerate results carry a zero tangent
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_tangent_x == 0 && rsp_tangent_y == 0 && rsp_tangent_z == 0)
      else $error("degenerate result with nonzero tangent");

   // a unit tangent stays in range and is not zero
   a_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |->
         rsp_tangent_x <= 16384 && rsp_tangent_x >= -16384
         && rsp_tangent_y <= 16384 && rsp_tangent_y >= -16384
         && rsp_tangent_z <= 16384 && rsp_tangent_z >= -16384
         && (rsp_tangent_x != 0 || rsp_tangent_y != 0 || rsp_tangent_z != 0))
      else $error("tangent out of range");

endmodule

bind triangle_tangent_calc_unit ttc_checker u_ttc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_corner     (req_corner),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_tangent_x  (rsp_tangent_x),
   .rsp_tangent_y  (rsp_tangent_y),
   .rsp_tangent_z  (rsp_tangent_z),
   .rsp_degenerate (rsp_degenerate)
);

[dv/triangle_tangent_checker.sv]
`timescale 1ns / 100ps

module triangle_tangent_checker
   import ttc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_corner,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic signed [UV_W-1:0]  req_tex_u,
   input  logic signed [UV_W-1:0]  req_tex_v,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic signed [OUT_W-1:0] rsp_tangent_x,
   input  logic signed [OUT_W-1:0] rsp_tangent_y,
   input  logic signed [OUT_W-1:0] rsp_tangent_z,
   input  logic                    rsp_handed_negative,
   input  logic                    rsp_degenerate,
   output int                      fail_count,
   output int                      tangents_pending
);

   typedef struct packed {
      logic signed [OUT_W-1:0] tx;
      logic signed [OUT_W-1:0] ty;
      logic signed [OUT_W-1:0] tz;
      logic                    handed_neg;
      logic                    degen;
   } tangent_type;

   tangent_type expected_tangents[$];
   longint      corner_pos[2][3];
   longint      corner_uv[2][2];

   function automatic bit [63:0] int_sqrt(input bit [63:0] n);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic tangent_type predict_tangent(input longint p[3], input longint u,
                                                   input longint v);
      tangent_type res;
      longint      e1, e2, du1, dv1, du2, dv2, det, t;
      bit [63:0]   mag[3], mx, sum, len, q;
      bit          neg[3];
      int          s;
      du1 = corner_uv[1][0] - corner_uv[0][0];
      dv1 = corner_uv[1][1] - corner_uv[0][1];
      du2 = u - corner_uv[0][0];
      dv2 = v - corner_uv[0][1];
      det = du1 * dv2 - du2 * dv1;
      mx = 0;
      for (int k = 0; k < 3; k++) begin
         e1 = corner_pos[1][k] - corner_pos[0][k];
         e2 = p[k] - corner_pos[0][k];
         t = dv2 * e1 - dv1 * e2;
         if (det < 0) t = -t;
         neg[k] = t < 0;
         mag[k] = neg[k] ? -t : t;
         if (mag[k] > mx) mx = mag[k];
      end
      res = '0;
      res.degen = (det == 0) || (mx == 0);
      res.handed_neg = det > 0;
      if (!res.degen) begin
         s = 0;
         while ((mx >> s) != 0) s++;
         s = (s > 31) ? s - 31 : 0;
         sum = 0;
         for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> s;
            sum += mag[k] * mag[k];
         end
         len = int_sqrt(sum);
         for (int k = 0; k < 3; k++) begin
            q = (mag[k] * 64'd16384 + (len >> 1)) / len;
            if (neg[k]) q = -q;
            if (k == 0) res.tx = q[OUT_W-1:0];
            else if (k == 1) res.ty = q[OUT_W-1:0];
            else res.tz = q[OUT_W-1:0];
         end
      end
      return res;
   endfunction

   assign tangents_pending = expected_tangents.size();

   always @(posedge clock) begin
      longint      p[3];
      tangent_type got, exp_t;
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) corner_pos[i][k] = 0;
            corner_uv[i][0] = 0;
            corner_uv[i][1] = 0;
         end
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_tangent_x, rsp_tangent_y, rsp_tangent_z, rsp_handed_negative,
                   rsp_degenerate};
            if (expected_tangents.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_t = expected_tangents.pop_front();
               if (got != exp_t) begin
                  $display("%0t: expected %0d %0d %0d %0b %0b, actual %0d %0d %0d %0b %0b",
                           $time, exp_t.tx, exp_t.ty, exp_t.tz, exp_t.handed_neg,
                           exp_t.degen, got.tx, got.ty, got.tz, got.handed_neg, got.degen);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            p[0] = req_pos_x;
            p[1] = req_pos_y;
            p[2] = req_pos_z;
            if (req_corner == CORNER_0 || req_corner == CORNER_1) begin
               for (int k = 0; k < 3; k++) corner_pos[req_corner][k] = p[k];
               corner_uv[req_corner][0] = req_tex_u;
               corner_uv[req_corner][1] = req_tex_v;
            end else if (req_corner == CORNER_2) begin
               expected_tangents = {expected_tangents,
                                    predict_tangent(p, req_tex_u, req_tex_v)};
            end
         end
      end
   end

endmodule

[dv/triangle_tangent_calc_unit_tb.sv]
`timescale 1ns / 100ps

module triangle_tangent_calc_unit_tb;
   import ttc_pkg::*;

   // corner code that the block ignores
   localparam logic [1:0] CORNER_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 600;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_corner = CORNER_0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [POS_W-1:0] req_pos_z = '0;
   logic signed [UV_W-1:0]  req_tex_u = '0;
   logic signed [UV_W-1:0]  req_tex_v = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic                    rsp_handed_negative, rsp_degenerate;
   int                      fail_count, tangents_pending;

   // idle percentages of sender and receiver, changed per phase
   int send_idle_pct = 17;
   int recv_idle_pct = 46;

   always #5 clock = ~clock;

   triangle_tangent_calc_unit u_dut (.*);
   triangle_tangent_checker u_checker (.*);

   // receiver stalls at random, only changes at the falling edge
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle_pct);
   end

   // one request: optional idle gap, then hold until the block takes it
   // valid stays high on return so the next request can follow directly
   task automatic send_corner(input logic [1:0] c, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [19:0] u,
                              input logic [19:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_corner <= c;
      req_pos_x  <= x;
      req_pos_y  <= y;
      req_pos_z  <= z;
      req_tex_u  <= u;
      req_tex_v  <= v;
      #1;
      // stall only moves at the rising edge, so its value now holds at the next one
      while (req_stall) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   // position value: mostly moderate so tangents are well formed, sometimes full range
   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2000) - 1000;
         default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic [19:0] rand_uv();
      if ($urandom_range(0, 2) == 0) return 20'($urandom);
      return 20'($urandom_range(0, 20'h2_0000) - 20'h1_0000);
   endfunction

   task automatic send_random_corner(input logic [1:0] c);
      send_corner(c, rand_pos(), rand_pos(), rand_pos(), rand_uv(), rand_uv());
   endtask

   // drop valid, then wait until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tangents_pending != 0) @(negedge clock);
   endtask

   initial begin
      int sent;
      int pick;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: corner 2 straight after reset uses zeroed held corners
      send_corner(CORNER_2, 32'h0001_0000, 32'h0, 32'h0, 20'h0_4000, 20'h0_8000);
      // plain right-angle triangle
      send_corner(CORNER_0, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0);
      send_corner(CORNER_1, 32'h0001_0000, 32'h0, 32'h0, 20'h1_0000, 20'h0);
      send_corner(CORNER_2, 32'h0, 32'h0001_0000, 32'h0, 20'h0, 20'h1_0000);
      // mirrored uv gives negative determinant, handed_negative clear
      send_corner(CORNER_2, 32'h0, 32'h0001_0000, 32'h0, 20'h0, 20'hF_0000);
      // zero determinant: all uvs equal
      send_corner(CORNER_1, 32'h0001_0000, 32'h0002_0000, 32'h0, 20'h0, 20'h0);
      send_corner(CORNER_2, 32'h0003_0000, 32'h0, 32'h0005_0000, 20'h0, 20'h0);
      // zero tangent vector: all positions equal but uvs spread
      send_corner(CORNER_0, 32'h1234, 32'h1234, 32'h1234, 20'h0, 20'h0);
      send_corner(CORNER_1, 32'h1234, 32'h1234, 32'h1234, 20'h1_0000, 20'h0);
      send_corner(CORNER_2, 32'h1234, 32'h1234, 32'h1234, 20'h0, 20'hF_0000);
      // extremes of every field, widest edges and uv deltas
      send_corner(CORNER_0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 20'h8_0000,
                  20'h7_FFFF);
      send_corner(CORNER_1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 20'h7_FFFF,
                  20'h8_0000);
      send_corner(CORNER_2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 20'h8_0000,
                  20'h8_0000);
      send_corner(CORNER_2, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 20'hF_FFFF, 20'h0_0001);
      // ignored corner code, then out-of-order and repeated corners
      send_corner(CORNER_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF,
                  20'hF_FFFF);
      send_corner(CORNER_1, 32'h0, 32'h0002_0000, 32'h0, 20'h0, 20'h1_0000);
      send_corner(CORNER_1, 32'h0, 32'h0, 32'h0003_0000, 20'h0_8000, 20'h0);
      send_corner(CORNER_0, 32'h0001_0000, 32'h0, 32'h0, 20'h0, 20'h0_8000);
      send_corner(CORNER_2, 32'h0, 32'h0001_0000, 32'h0001_0000, 20'h1_0000, 20'h1_0000);
      send_corner(CORNER_NONE, 32'h0, 32'h0, 32'h0, 20'h0, 20'h0);
      send_corner(CORNER_2, 32'h0002_0000, 32'h0, 32'h0, 20'h0, 20'h0);

      // hold off until the block has returned everything
      wait_drained();

      // random: mostly whole triangles with random content, some noise
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 17;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_random_corner(CORNER_0);
            send_random_corner(CORNER_1);
            send_random_corner(CORNER_2);
            sent += 3;
         end else if (pick < 9) begin
            send_random_corner(2'($urandom_range(0, 2)));
            sent += 1;
         end else begin
            send_random_corner(CORNER_NONE);
         end
      end

      wait_drained();
      repeat (150) @(negedge clock);
      if (fail_count == 0) begin
         $display("triangle_tangent_calc_unit regression: pass");
      end else begin
         $display("triangle_tangent_calc_unit regression: fail");
      end
      $finish;
   end

   // watchdog for a hung handshake
   initial begin
      #20ms;
      $display("triangle_tangent_calc_unit regression: fail");
      $finish;
   end

endmodule
